// ----- rtl/mivp_pkg.sv -----
// Package for the MessagePack id/value parser: parse phases, state and result
// structs, protocol byte codes and the key character tables.
// No dependencies.
`default_nettype none

package mivp_pkg;

  typedef enum logic [3:0] {
    PH_MAP       = 4'd0,
    PH_IDKEYHDR  = 4'd1,
    PH_IDKEY     = 4'd2,
    PH_IDHDR     = 4'd3,
    PH_IDDATA    = 4'd4,
    PH_VALKEYHDR = 4'd5,
    PH_VALKEY    = 4'd6,
    PH_VALHDR    = 4'd7,
    PH_VALDATA   = 4'd8
  } mivp_phase_t;

  localparam logic [7:0] MAP_HDR_BYTE = 8'h82;
  localparam logic [7:0] ID_KEY_HDR   = 8'hA2;
  localparam logic [7:0] VAL_KEY_HDR  = 8'hA5;
  localparam logic [7:0] UINT8_HDR    = 8'hCC;
  localparam logic [7:0] UINT16_HDR   = 8'hCD;
  localparam logic [7:0] UINT32_HDR   = 8'hCE;
  localparam logic [7:0] UINT64_HDR   = 8'hCF;

  localparam logic [3:0] ID_KEY_LEN  = 4'd2;
  localparam logic [3:0] VAL_KEY_LEN = 4'd5;
  localparam logic [3:0] LEN_FIXINT  = 4'd0;
  localparam logic [3:0] LEN_REJECT  = 4'd15;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    mivp_phase_t phase;
    logic [3:0]  bytes_left;
    logic [63:0] acc;
    logic [63:0] held_id;
    logic        key_mismatch;
  } mivp_state_t;

  typedef struct packed {
    logic [63:0] msg_id;
    logic [63:0] msg_value;
    logic        status;
  } mivp_result_t;

  // Expected key character, indexed by the count of key bytes still to come.
  function automatic logic [7:0] id_key_char(input logic [3:0] left);
    logic [7:0] c;
    unique case (left)
      4'd2:    c = 8'h69; // 'i'
      4'd1:    c = 8'h64; // 'd'
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] val_key_char(input logic [3:0] left);
    logic [7:0] c;
    unique case (left)
      4'd5:    c = 8'h76; // 'v'
      4'd4:    c = 8'h61; // 'a'
      4'd3:    c = 8'h6C; // 'l'
      4'd2:    c = 8'h75; // 'u'
      4'd1:    c = 8'h65; // 'e'
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Payload length of an unsigned int header; LEN_REJECT for anything else.
  function automatic logic [3:0] int_len(input logic [7:0] b);
    logic [3:0] n;
    if (!b[7]) begin
      n = LEN_FIXINT;
    end else begin
      unique case (b)
        UINT8_HDR:  n = 4'd1;
        UINT16_HDR: n = 4'd2;
        UINT32_HDR: n = 4'd4;
        UINT64_HDR: n = 4'd8;
        default:    n = LEN_REJECT;
      endcase
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mivp_if.sv -----
// Stream interfaces for the MessagePack id/value parser: byte input and
// result output, each with valid/ready handshake. No dependencies.
`default_nettype none

interface mivp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mivp_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] msg_id;
  logic [63:0] msg_value;
  logic        status;
  modport source (output valid, output msg_id, output msg_value, output status,
                  input ready);
  modport sink   (input valid, input msg_id, input msg_value, input status,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/mivp_step.sv -----
// Single-byte parse step: next parser state and optional result for one byte.
// Depends on mivp_pkg.
`default_nettype none

module mivp_step (
  input  wire logic [7:0]           rx_byte,
  input  wire mivp_pkg::mivp_state_t  state,
  output      mivp_pkg::mivp_state_t  state_next,
  output      logic                   emit,
  output      mivp_pkg::mivp_result_t result
);

  logic [3:0] len;
  logic [3:0] left_dec;
  logic       km;
  logic       fail;

  assign len      = mivp_pkg::int_len(rx_byte);
  assign left_dec = state.bytes_left - 4'd1;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    fail       = 1'b0;
    km         = state.key_mismatch;
    result     = '{msg_id: state.held_id, msg_value: '0, status: mivp_pkg::STATUS_OK};

    unique case (state.phase)
      mivp_pkg::PH_IDKEYHDR: begin
        if (rx_byte != mivp_pkg::ID_KEY_HDR) begin
          fail = 1'b1;
        end else begin
          state_next.phase        = mivp_pkg::PH_IDKEY;
          state_next.bytes_left   = mivp_pkg::ID_KEY_LEN;
          state_next.key_mismatch = 1'b0;
        end
      end
      mivp_pkg::PH_VALKEYHDR: begin
        if (rx_byte != mivp_pkg::VAL_KEY_HDR) begin
          fail = 1'b1;
        end else begin
          state_next.phase        = mivp_pkg::PH_VALKEY;
          state_next.bytes_left   = mivp_pkg::VAL_KEY_LEN;
          state_next.key_mismatch = 1'b0;
        end
      end
      mivp_pkg::PH_IDKEY, mivp_pkg::PH_VALKEY: begin
        if (state.phase == mivp_pkg::PH_IDKEY) begin
          if (rx_byte != mivp_pkg::id_key_char(state.bytes_left)) km = 1'b1;
        end else begin
          if (rx_byte != mivp_pkg::val_key_char(state.bytes_left)) km = 1'b1;
        end
        state_next.key_mismatch = km;
        state_next.bytes_left   = left_dec;
        if (left_dec == 4'd0) begin
          if (km) begin
            fail = 1'b1;
          end else begin
            state_next.phase = (state.phase == mivp_pkg::PH_IDKEY) ?
                               mivp_pkg::PH_IDHDR : mivp_pkg::PH_VALHDR;
          end
        end
      end
      mivp_pkg::PH_IDHDR, mivp_pkg::PH_VALHDR: begin
        if (len == mivp_pkg::LEN_REJECT) begin
          fail = 1'b1;
        end else if (len == mivp_pkg::LEN_FIXINT) begin
          if (state.phase == mivp_pkg::PH_IDHDR) begin
            state_next.held_id = {56'd0, rx_byte};
            state_next.phase   = mivp_pkg::PH_VALKEYHDR;
          end else begin
            state_next.phase = mivp_pkg::PH_MAP;
            emit             = 1'b1;
            result.msg_value = {56'd0, rx_byte};
          end
        end else begin
          state_next.bytes_left = len;
          state_next.acc        = '0;
          state_next.phase      = (state.phase == mivp_pkg::PH_IDHDR) ?
                                  mivp_pkg::PH_IDDATA : mivp_pkg::PH_VALDATA;
        end
      end
      mivp_pkg::PH_IDDATA, mivp_pkg::PH_VALDATA: begin
        state_next.acc        = {state.acc[55:0], rx_byte};
        state_next.bytes_left = left_dec;
        if (left_dec == 4'd0) begin
          if (state.phase == mivp_pkg::PH_IDDATA) begin
            state_next.held_id = {state.acc[55:0], rx_byte};
            state_next.phase   = mivp_pkg::PH_VALKEYHDR;
          end else begin
            state_next.phase = mivp_pkg::PH_MAP;
            emit             = 1'b1;
            result.msg_value = {state.acc[55:0], rx_byte};
          end
        end
      end
      default: begin
        // Map header, and any unreachable phase code.
        if (rx_byte != mivp_pkg::MAP_HDR_BYTE) begin
          fail = 1'b1;
        end else begin
          state_next.phase        = mivp_pkg::PH_IDKEYHDR;
          state_next.bytes_left   = 4'd0;
          state_next.key_mismatch = 1'b0;
        end
      end
    endcase

    if (fail) begin
      // Drop the message, keep held_id, resynchronise on a map header.
      state_next.phase        = mivp_pkg::PH_MAP;
      state_next.bytes_left   = 4'd0;
      state_next.acc          = '0;
      state_next.key_mismatch = 1'b0;
      emit                    = 1'b1;
      result                  = '{msg_id: '0, msg_value: '0,
                                  status: mivp_pkg::STATUS_ERR};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mivp_out_reg.sv -----
// Result register: holds one result beat until the sink takes it.
// Depends on mivp_pkg and mivp_res_if.
`default_nettype none

module mivp_out_reg (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire mivp_pkg::mivp_result_t data,
  output      logic                   can_load,
  mivp_res_if.source                  res
);

  logic                   valid;
  mivp_pkg::mivp_result_t held;

  // Free when empty or when the held beat leaves this cycle.
  assign can_load = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      held <= data;
    end
  end

  assign res.valid     = valid;
  assign res.msg_id    = held.msg_id;
  assign res.msg_value = held.msg_value;
  assign res.status    = held.status;

endmodule

`default_nettype wire

// ----- rtl/msgpack_id_value_parser.sv -----
// MessagePack id/value parser top level: parser state register, parse step
// and result register. Depends on mivp_pkg, mivp_if, mivp_step, mivp_out_reg.
//
// Takes one MessagePack byte per beat on rx and recognises the message
// {"id": uint, "value": uint} encoded as fixmap(2), fixstr "id", unsigned int,
// fixstr "value", unsigned int. Each int is a positive fixint or a uint8,
// uint16, uint32 or uint64 payload in big-endian order. On the last byte of a
// good message one beat leaves on result with status 0 and both values. Any
// malformed byte gives one beat with status 1 and zero values, and the parser
// then expects a map header again; a wrong key is reported on the key's last
// byte. Bytes that complete nothing produce no beat. Rate: one byte per clock
// while the sink keeps up. Each byte is decoded combinationally from the parser
// state register into the one-entry result register; rx stalls only while that
// register holds a beat the sink has not taken.
`default_nettype none

module msgpack_id_value_parser (
  input wire logic  clk,
  input wire logic  rst,
  mivp_rx_if.sink   rx,
  mivp_res_if.source result
);

  mivp_pkg::mivp_state_t  state;
  mivp_pkg::mivp_state_t  state_next;
  mivp_pkg::mivp_result_t step_res;
  logic                   step_emit;
  logic                   can_load;
  logic                   accept;

  // Accept a byte whenever the result register can take what it may cause.
  assign rx.ready = can_load;
  assign accept   = rx.valid && can_load;

  mivp_step u_step (
    .rx_byte    (rx.rx_byte),
    .state      (state),
    .state_next (state_next),
    .emit       (step_emit),
    .result     (step_res)
  );

  // Parser state: advance once per accepted byte, hold otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: mivp_pkg::PH_MAP, bytes_left: 4'd0, acc: 64'd0,
                 held_id: 64'd0, key_mismatch: 1'b0};
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Result register: load only when the byte closes a message or fails it.
  mivp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && step_emit),
    .data     (step_res),
    .can_load (can_load),
    .res      (result)
  );

`ifndef SYNTH
  // An error always sends the parser back to the map header.
  a_err_resync: assert property (@(posedge clk) disable iff (rst)
    accept && step_emit && step_res.status == mivp_pkg::STATUS_ERR
    |=> state.phase == mivp_pkg::PH_MAP)
    else $error("parser did not resynchronise after an error");

  // Key and payload phases always have bytes still to come.
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (state.phase == mivp_pkg::PH_IDKEY || state.phase == mivp_pkg::PH_VALKEY ||
     state.phase == mivp_pkg::PH_IDDATA || state.phase == mivp_pkg::PH_VALDATA)
    |-> state.bytes_left != 4'd0 && state.bytes_left <= 4'd8)
    else $error("byte counter out of range in a counted phase");

  // A good message completes only from a value header or value payload.
  a_ok_source: assert property (@(posedge clk) disable iff (rst)
    accept && step_emit && step_res.status == mivp_pkg::STATUS_OK
    |-> state.phase == mivp_pkg::PH_VALHDR || state.phase == mivp_pkg::PH_VALDATA)
    else $error("ok result from a phase that cannot end a message");
`endif

endmodule

`default_nettype wire
